### rtl/core/erp_pkg.sv
`default_nettype none

package erp_pkg;

  // Parser phases
  typedef enum logic [3:0] {
    PH_OPC    = 4'd0,
    PH_DONE   = 4'd1,
    PH_SKIP1  = 4'd2,
    PH_OTYPE  = 4'd3,
    PH_DSTR   = 4'd4,
    PH_DINT   = 4'd5,
    PH_CNT5   = 4'd6,
    PH_CNT6   = 4'd7,
    PH_CNT7   = 4'd8,
    PH_KEY5   = 4'd9,
    PH_STR5   = 4'd10,
    PH_DROP5  = 4'd11,
    PH_KEY6   = 4'd12,
    PH_VAL6   = 4'd13,
    PH_SKIP12 = 4'd14,
    PH_SKIP8  = 4'd15
  } erp_phase_e;

  // Opcodes
  localparam logic [7:0] OPC_END     = 8'd0;
  localparam logic [7:0] OPC_SKIP1   = 8'd1;
  localparam logic [7:0] OPC_OTYPE   = 8'd2;
  localparam logic [7:0] OPC_DSTR    = 8'd3;
  localparam logic [7:0] OPC_DINT    = 8'd4;
  localparam logic [7:0] OPC_STRLIST = 8'd5;
  localparam logic [7:0] OPC_INTLIST = 8'd6;
  localparam logic [7:0] OPC_SKIPLST = 8'd7;
  localparam logic [7:0] OPC_SKIP8   = 8'd8;

  localparam logic [7:0] CHAR_S = 8'h73;

  // Result kinds
  localparam logic [3:0] KIND_NONE      = 4'd0;
  localparam logic [3:0] KIND_OTYPE     = 4'd1;
  localparam logic [3:0] KIND_DEF_INT   = 4'd2;
  localparam logic [3:0] KIND_DEF_CHAR  = 4'd3;
  localparam logic [3:0] KIND_DEF_END   = 4'd4;
  localparam logic [3:0] KIND_INT_ENTRY = 4'd5;
  localparam logic [3:0] KIND_STR_KEY   = 4'd6;
  localparam logic [3:0] KIND_STR_CHAR  = 4'd7;
  localparam logic [3:0] KIND_STR_END   = 4'd8;

  localparam int unsigned IDX_W = 12;

  typedef struct packed {
    logic [3:0]       kind;
    logic [31:0]      entry_key;
    logic [31:0]      int_value;
    logic [7:0]       text_char;
    logic [IDX_W-1:0] entry_index;
    logic             record_done;
    logic             truncated;
    logic             table_overflow;
  } erp_result_t;

  // Shift one byte into a multi-byte field
  function automatic logic [31:0] take_byte(input logic [31:0] acc, input logic [7:0] b,
                                            input logic be, input logic [3:0] cnt);
    logic [31:0] r;
    if (be) begin
      r = {acc[23:0], b};
    end else begin
      r = acc | (32'(b) << {cnt[1:0], 3'b000});
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/erp_parse_core.sv
`default_nettype none

module erp_parse_core
  import erp_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  byte_i,
  input  wire logic        last_i,
  input  wire logic        big_endian_i,
  output erp_result_t      res_o,
  output logic             emit_o
);

  localparam int unsigned TOTAL_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned EXT_W   = (TOTAL_W > IDX_W) ? TOTAL_W : IDX_W;

  erp_phase_e         phase_q, phase_d;
  logic [3:0]         cnt_q, cnt_d;
  logic [31:0]        key_q, key_d;
  logic [31:0]        val_q, val_d;
  logic [15:0]        left_q, left_d;
  logic [TOTAL_W-1:0] total_q, total_d;

  logic [3:0]         cnt_inc;
  logic [15:0]        left_dec;
  logic [31:0]        key_take, val_take;
  logic               table_full;
  logic [EXT_W-1:0]   total_ext;
  logic [IDX_W-1:0]   cur_idx;

  assign cnt_inc    = cnt_q + 4'd1;
  assign left_dec   = left_q - 16'd1;
  assign key_take   = take_byte(key_q, byte_i, big_endian_i, cnt_q);
  assign val_take   = take_byte(val_q, byte_i, big_endian_i, cnt_q);
  assign table_full = (total_q == TOTAL_W'(MAX_ENTRIES));
  assign total_ext  = EXT_W'(total_q);
  assign cur_idx    = total_ext[IDX_W-1:0];

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    key_d   = key_q;
    val_d   = val_q;
    left_d  = left_q;
    total_d = total_q;
    res_o   = '0;
    emit_o  = 1'b0;

    case (phase_q)
      PH_OPC: begin
        cnt_d = '0;
        key_d = '0;
        val_d = '0;
        case (byte_i)
          OPC_END: begin
            res_o.record_done = 1'b1;
            emit_o  = 1'b1;
            phase_d = PH_DONE;
          end
          OPC_SKIP1:   phase_d = PH_SKIP1;
          OPC_OTYPE:   phase_d = PH_OTYPE;
          OPC_DSTR:    phase_d = PH_DSTR;
          OPC_DINT:    phase_d = PH_DINT;
          OPC_STRLIST: phase_d = PH_CNT5;
          OPC_INTLIST: phase_d = PH_CNT6;
          OPC_SKIPLST: phase_d = PH_CNT7;
          OPC_SKIP8:   phase_d = PH_SKIP8;
          default:     phase_d = PH_OPC;
        endcase
      end
      PH_DONE: phase_d = PH_DONE;
      PH_SKIP1: phase_d = PH_OPC;
      PH_OTYPE: begin
        res_o.kind      = KIND_OTYPE;
        res_o.int_value = {31'd0, (byte_i == CHAR_S)};
        emit_o  = 1'b1;
        phase_d = PH_OPC;
      end
      PH_DSTR: begin
        emit_o = 1'b1;
        if (byte_i != 8'd0) begin
          res_o.kind      = KIND_DEF_CHAR;
          res_o.text_char = byte_i;
        end else begin
          res_o.kind = KIND_DEF_END;
          phase_d    = PH_OPC;
        end
      end
      PH_DINT: begin
        val_d = val_take;
        cnt_d = cnt_inc;
        if (cnt_inc == 4'd4) begin
          res_o.kind      = KIND_DEF_INT;
          res_o.int_value = val_take;
          emit_o  = 1'b1;
          phase_d = PH_OPC;
        end
      end
      PH_CNT5, PH_CNT6, PH_CNT7: begin
        val_d = val_take;
        cnt_d = cnt_inc;
        if (cnt_inc == 4'd2) begin
          left_d = val_take[15:0];
          cnt_d  = '0;
          val_d  = '0;
          key_d  = '0;
          if (val_take[15:0] == 16'd0) begin
            phase_d = PH_OPC;
          end else if (phase_q == PH_CNT5) begin
            phase_d = PH_KEY5;
          end else if (phase_q == PH_CNT6) begin
            phase_d = PH_KEY6;
          end else begin
            phase_d = PH_SKIP12;
          end
        end
      end
      PH_KEY5: begin
        key_d = key_take;
        cnt_d = cnt_inc;
        if (cnt_inc == 4'd4) begin
          cnt_d             = '0;
          res_o.entry_key   = key_take;
          res_o.entry_index = cur_idx;
          emit_o            = 1'b1;
          if (table_full) begin
            res_o.table_overflow = 1'b1;
            phase_d = PH_DROP5;
          end else begin
            res_o.kind = KIND_STR_KEY;
            phase_d    = PH_STR5;
          end
        end
      end
      PH_STR5: begin
        res_o.entry_key   = key_q;
        res_o.entry_index = cur_idx;
        emit_o            = 1'b1;
        if (byte_i != 8'd0) begin
          res_o.kind      = KIND_STR_CHAR;
          res_o.text_char = byte_i;
        end else begin
          res_o.kind = KIND_STR_END;
          total_d    = total_q + TOTAL_W'(1);
          left_d     = left_dec;
          cnt_d      = '0;
          key_d      = '0;
          val_d      = '0;
          phase_d    = (left_dec != 16'd0) ? PH_KEY5 : PH_OPC;
        end
      end
      PH_DROP5: begin
        if (byte_i == 8'd0) begin
          left_d  = left_dec;
          cnt_d   = '0;
          key_d   = '0;
          val_d   = '0;
          phase_d = (left_dec != 16'd0) ? PH_KEY5 : PH_OPC;
        end
      end
      PH_KEY6: begin
        key_d = key_take;
        cnt_d = cnt_inc;
        if (cnt_inc == 4'd4) begin
          cnt_d   = '0;
          val_d   = '0;
          phase_d = PH_VAL6;
        end
      end
      PH_VAL6: begin
        val_d = val_take;
        cnt_d = cnt_inc;
        if (cnt_inc == 4'd4) begin
          res_o.entry_key   = key_q;
          res_o.entry_index = cur_idx;
          emit_o            = 1'b1;
          if (table_full) begin
            res_o.table_overflow = 1'b1;
          end else begin
            res_o.kind      = KIND_INT_ENTRY;
            res_o.int_value = val_take;
            total_d         = total_q + TOTAL_W'(1);
          end
          left_d  = left_dec;
          cnt_d   = '0;
          key_d   = '0;
          val_d   = '0;
          phase_d = (left_dec != 16'd0) ? PH_KEY6 : PH_OPC;
        end
      end
      PH_SKIP12: begin
        cnt_d = cnt_inc;
        if (cnt_inc == 4'd12) begin
          left_d  = left_dec;
          cnt_d   = '0;
          key_d   = '0;
          val_d   = '0;
          phase_d = (left_dec != 16'd0) ? PH_SKIP12 : PH_OPC;
        end
      end
      PH_SKIP8: begin
        cnt_d = cnt_inc;
        if (cnt_inc == 4'd8) begin
          phase_d = PH_OPC;
        end
      end
      default: phase_d = PH_OPC;
    endcase

    // End of buffer: flag a record cut short, then start over
    if (last_i) begin
      if (phase_d != PH_DONE) begin
        res_o.truncated = 1'b1;
        emit_o          = 1'b1;
      end
      phase_d = PH_OPC;
      cnt_d   = '0;
      key_d   = '0;
      val_d   = '0;
      left_d  = '0;
      total_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OPC;
      cnt_q   <= '0;
      key_q   <= '0;
      val_q   <= '0;
      left_q  <= '0;
      total_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      key_q   <= key_d;
      val_q   <= val_d;
      left_q  <= left_d;
      total_q <= total_d;
    end
  end

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> phase_q == PH_OPC && total_q == '0 && left_q == 16'd0)
    else $error("state not cleared after last word");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TOTAL_W'(MAX_ENTRIES))
    else $error("entry total beyond capacity");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 4'd11)
    else $error("field byte count out of range");

  a_list_has_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_KEY5 || phase_q == PH_KEY6 || phase_q == PH_SKIP12
     || phase_q == PH_STR5 || phase_q == PH_VAL6 || phase_q == PH_DROP5)
    |-> left_q != 16'd0)
    else $error("list phase with no entries left");

endmodule

`default_nettype wire

### rtl/core/erp_out_reg.sv
`default_nettype none

module erp_out_reg
  import erp_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire logic         emit_i,
  input  wire erp_result_t  res_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output erp_result_t       res_o
);

  logic        valid_q, valid_d;
  erp_result_t res_q;
  logic        load;

  // Slot frees up at this edge when empty or being taken
  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o && emit_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

### rtl/core/enum_record_stream_parser.sv
`default_nettype none

// Opcode-stream record parser. Record bytes enter on the slave stream, one
// word per byte, with tlast on the final byte of the buffer; each byte is
// decoded in the cycle it is accepted and any result lands in an output
// register in the next cycle. Throughput is one byte per cycle: the parse
// state register closes its loop combinationally, and the output register
// takes a new result in the same cycle the old one is drained. Stalls on the
// master side stall the slave side only while a result is pending. Table
// entries from opcodes 5 and 6 share one index; entries past MAX_ENTRIES are
// dropped and flagged. big_endian may only be written while the stream is idle.
module enum_record_stream_parser
  import erp_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,   // big_endian
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  wire logic        s_axis_tlast,  // last_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [31:0] entry_key, [63:32] int_value, [71:64] text_char,
  // [83:72] entry_index, [87:84] zero
  output logic [87:0]      m_axis_tdata,
  // [3:0] kind, [4] record_done, [5] truncated, [6] table_overflow, [7] zero
  output logic [7:0]       m_axis_tuser
);

  logic        big_endian_q;
  logic        step;
  logic        emit;
  erp_result_t res_core, res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      big_endian_q <= 1'b1;
    end else if (cfg_we_i) begin
      big_endian_q <= cfg_wdata_i;
    end
  end

  assign step = s_axis_tvalid && s_axis_tready;

  erp_parse_core #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .byte_i       (s_axis_tdata),
    .last_i       (s_axis_tlast),
    .big_endian_i (big_endian_q),
    .res_o        (res_core),
    .emit_o       (emit)
  );

  erp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .emit_i      (emit),
    .res_i       (res_core),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res_out)
  );

  assign m_axis_tdata = {4'd0, res_out.entry_index, res_out.text_char,
                         res_out.int_value, res_out.entry_key};
  assign m_axis_tuser = {1'b0, res_out.table_overflow, res_out.truncated,
                         res_out.record_done, res_out.kind};

endmodule

`default_nettype wire
